/* design/gle_pkg.sv */
// ============================================================================
// gle_pkg
// Shared types for the GCD/LCM engine: controller commands and datapath status.
// ============================================================================
package gle_pkg;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;       // capture operands and order them
        logic gcd_step;   // one binary GCD step
        logic gcd_latch;  // form the GCD and arm the divider
        logic div_step;   // one restoring division step
        logic mul;        // quotient times smaller operand
        logic out_load;   // move results into the output register
    } gle_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic in_zero;    // an incoming operand is zero
        logic gcd_done;   // reduction has finished
        logic div_last;   // current division step is the last one
    } gle_status_t;

endpackage

/* design/gle_datapath.sv */
// ============================================================================
// gle_datapath
// Operand registers, binary GCD reducer, shift-subtract divider, multiplier
// and the output register of the GCD/LCM engine.
// ============================================================================
module gle_datapath #(
    parameter int OPW = 31
) (
    input  logic               aclk,
    input  logic [30:0]        first_value,
    input  logic [30:0]        second_value,
    input  gle_pkg::gle_cmd_t  cmd,
    output gle_pkg::gle_status_t status,
    output logic [30:0]        divisor_result,
    output logic [61:0]        multiple_result,
    output logic               zero_error
);
    import gle_pkg::*;

    localparam int KW = $clog2(OPW);

    logic [OPW-1:0]   a_op;
    logic [OPW-1:0]   b_op;
    logic             in_zero;

    logic [OPW-1:0]   u_reg;
    logic [OPW-1:0]   v_reg;
    logic [KW-1:0]    k_reg;
    logic [OPW-1:0]   big_reg;
    logic [OPW-1:0]   small_reg;
    logic             err_reg;
    logic [OPW-1:0]   g_reg;
    logic [OPW-1:0]   rem_reg;
    logic [OPW-1:0]   quo_reg;
    logic [KW-1:0]    cnt_reg;
    logic [2*OPW-1:0] prod_reg;
    logic [30:0]      out_div_reg;
    logic [61:0]      out_mul_reg;
    logic             out_err_reg;

    logic [OPW:0]     trial;
    logic             fits;
    logic [OPW:0]     trial_diff;
    logic [31:0]      g_ext;
    logic [63:0]      prod_ext;

    // Operands masked to the configured width.
    assign a_op    = OPW'(first_value);
    assign b_op    = OPW'(second_value);
    assign in_zero = (a_op == '0) || (b_op == '0);

    // One restoring division step: shift in the next dividend bit, try to subtract.
    assign trial      = {rem_reg, quo_reg[OPW-1]};
    assign trial_diff = trial - {1'b0, g_reg};
    assign fits       = (trial >= {1'b0, g_reg});

    assign g_ext    = 32'(g_reg);
    assign prod_ext = 64'(prod_reg);

    // Operand, reduction and division registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            big_reg   <= (a_op > b_op) ? a_op : b_op;
            small_reg <= (a_op > b_op) ? b_op : a_op;
            u_reg     <= (a_op > b_op) ? a_op : b_op;
            v_reg     <= (a_op > b_op) ? b_op : a_op;
            k_reg     <= '0;
            err_reg   <= in_zero;
        end else if (cmd.gcd_step) begin
            // Binary GCD: strip common twos, then odd values reduce by halved difference.
            if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg > v_reg) begin
                u_reg <= v_reg;
                v_reg <= (u_reg - v_reg) >> 1;
            end else begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end else if (cmd.gcd_latch) begin
            g_reg   <= u_reg << k_reg;
            rem_reg <= '0;
            quo_reg <= big_reg;
            cnt_reg <= KW'(OPW - 1);
        end else if (cmd.div_step) begin
            rem_reg <= fits ? trial_diff[OPW-1:0] : trial[OPW-1:0];
            quo_reg <= {quo_reg[OPW-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end else if (cmd.mul) begin
            prod_reg <= quo_reg * small_reg;
        end
    end

    // Output register; a zero operand forces both results to zero.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_div_reg <= err_reg ? '0 : g_ext[30:0];
            out_mul_reg <= err_reg ? '0 : prod_ext[61:0];
            out_err_reg <= err_reg;
        end
    end

    assign status.in_zero  = in_zero;
    assign status.gcd_done = (v_reg == '0);
    assign status.div_last = (cnt_reg == '0);

    assign divisor_result  = out_div_reg;
    assign multiple_result = out_mul_reg;
    assign zero_error      = out_err_reg;

endmodule

/* design/gle_controller.sv */
// ============================================================================
// gle_controller
// Sequencer of the GCD/LCM engine: steps the datapath through load, GCD
// reduction, division and multiplication, and owns the output valid flag.
// ============================================================================
module gle_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  gle_pkg::gle_status_t status,
    output gle_pkg::gle_cmd_t    cmd
);
    import gle_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GCD    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_zero ? ST_FINISH : ST_GCD;
                end
            end
            ST_GCD: begin
                if (status.gcd_done) begin
                    cmd.gcd_latch = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and downstream acceptance.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* design/gcd_lcm_engine_core.sv */
// ============================================================================
// gcd_lcm_engine_core
// Greatest common divisor and least common multiple of two unsigned operands.
// ============================================================================
//
//  Channel | Direction | tdata fields (low bit up)               | tuser
//  --------+-----------+-------------------------------------------+-----------
//  s_      | in        | first_value[30:0], second_value[61:31]    | none
//  m_      | out       | divisor_result[30:0], multiple_result     | zero_error
//          |           | [92:31]                                   |
//
//  One word at a time. A pair passes through a load, up to 2*OPERAND_BITS binary
//  GCD steps (one shift or subtract-and-shift per cycle), forming the GCD,
//  OPERAND_BITS restoring division steps, a multiply and an output load.
//  A zero operand goes straight from the load to the output load.
//  Most of the work is in the GCD loop and the shift-subtract divider.
//  A finished result sits in the output register while the next word is
//  taken; the engine only stalls in its last cycle if that register is full.
//  Reset is synchronous and active low and clears the control state only.
//
module gcd_lcm_engine_core #(
    parameter int OPERAND_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // first_value[30:0], second_value[61:31], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // divisor_result[30:0], multiple_result[92:31], zero pad
    output logic        m_tuser    // zero_error
);
    import gle_pkg::*;

    gle_cmd_t    cmd;
    gle_status_t status;
    logic [30:0] divisor_result;
    logic [61:0] multiple_result;
    logic        zero_error;

    gle_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gle_datapath #(
        .OPW (OPERAND_BITS)
    ) u_dp (
        .aclk            (aclk),
        .first_value     (s_tdata[30:0]),
        .second_value    (s_tdata[61:31]),
        .cmd             (cmd),
        .status          (status),
        .divisor_result  (divisor_result),
        .multiple_result (multiple_result),
        .zero_error      (zero_error)
    );

    assign m_tdata = {3'b000, multiple_result, divisor_result};
    assign m_tuser = zero_error;

    // The engine works on one word at a time: no second accept right after one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // An error result carries zero in both result fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[92:0] == '0))
        else $error("error result with nonzero fields");

    // A valid result without error always has a nonzero GCD and LCM.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[30:0] != '0) && (m_tdata[92:31] != '0))
        else $error("zero GCD or LCM without error");

endmodule

/* dv/gcd_lcm_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// gcd_lcm_checker
// Watches both stream channels of the GCD/LCM engine, predicts each result
// word from the accepted operand word and compares the two field by field.
// ============================================================================
module gcd_lcm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // first_value[30:0], second_value[61:31], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // divisor_result[30:0], multiple_result[92:31], zero pad
    input  logic        m_tuser,   // zero_error
    output int          error_count,
    output int          pending_count
);

    // One expected result word.
    typedef struct packed {
        bit [30:0] divisor;
        bit [61:0] multiple;
        bit        zero_error;
    } gcd_lcm_t;

    gcd_lcm_t expected_q[$];

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // Euclid on the ordered operands; the LCM is (greater / gcd) * lesser.
    function automatic gcd_lcm_t predict_gcd_lcm(input bit [30:0] a, input bit [30:0] b);
        gcd_lcm_t  r;
        bit [63:0] greater;
        bit [63:0] lesser;
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] rest;
        bit [63:0] product;
        r = '0;
        if (a == 0 || b == 0) begin
            r.zero_error = 1'b1;
            return r;
        end
        greater = 64'((a > b) ? a : b);
        lesser  = 64'((a > b) ? b : a);
        x = greater;
        y = lesser;
        while (y != 0) begin
            rest = x % y;
            x = y;
            y = rest;
        end
        product    = (greater / x) * lesser;
        r.divisor  = x[30:0];
        r.multiple = product[61:0];
        return r;
    endfunction

    // Queue a prediction on each accepted operand word and check each result word.
    always @(posedge aclk) begin
        gcd_lcm_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_gcd_lcm(s_tdata[30:0], s_tdata[61:31]));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h / %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[30:0] !== want.divisor)
                        report_mismatch($sformatf("divisor_result got %0d want %0d",
                                                  m_tdata[30:0], want.divisor));
                    if (m_tdata[92:31] !== want.multiple)
                        report_mismatch($sformatf("multiple_result got %0d want %0d",
                                                  m_tdata[92:31], want.multiple));
                    if (m_tuser !== want.zero_error)
                        report_mismatch($sformatf("zero_error got %b want %b",
                                                  m_tuser, want.zero_error));
                end
            end
            pending_count = expected_q.size();
        end
    end

endmodule

/* dv/tb_gcd_lcm_engine_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_gcd_lcm_engine_core
// Drives operand pairs into the GCD/LCM engine with random gaps and result
// stalls; a separate checker predicts and compares every result word.
// ============================================================================
module tb_gcd_lcm_engine_core;

    localparam bit [30:0] OPERAND_MAX = 31'h7FFF_FFFF;
    localparam int        RANDOM_PAIRS = 450;
    localparam int        DRAIN_CYCLES = 150;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;
    int          error_count;
    int          pending_count;

    bit          send_quiet;
    bit          recv_quiet;

    gcd_lcm_engine_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gcd_lcm_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: stall a random number of cycles before each word, with
    // stretches where the sink is always ready.
    initial begin
        int unsigned stall;
        int          words;
        m_tready = 1'b0;
        words    = 0;
        recv_quiet = 1'b0;
        @(posedge aresetn);
        forever begin
            if (words % 37 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            stall = recv_quiet ? 0 : $urandom_range(0, 17);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            words++;
        end
    end

    // Sends one operand word after a random gap and waits for it to be taken.
    task automatic send_pair(input bit [30:0] a, input bit [30:0] b);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, b, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random operand pairs of several shapes: full range, small values,
    // shared factors, powers of two, equal operands, multiples and zero operands.
    task automatic make_pair(output bit [30:0] a, output bit [30:0] b);
        bit [31:0] factor;
        case ($urandom_range(0, 9)) inside
            [0:2]: begin
                a = 31'($urandom_range(1, OPERAND_MAX));
                b = 31'($urandom_range(1, OPERAND_MAX));
            end
            3: begin
                a = 31'($urandom_range(1, 1000));
                b = 31'($urandom_range(1, 1000));
            end
            [4:5]: begin
                factor = $urandom_range(1, 65535);
                a = 31'(factor * $urandom_range(1, 32767));
                b = 31'(factor * $urandom_range(1, 32767));
            end
            6: begin
                a = 31'(1) << $urandom_range(0, 30);
                b = 31'($urandom_range(1, OPERAND_MAX)
                        & (OPERAND_MAX << $urandom_range(0, 20)));
                if (b == 0)
                    b = 31'(1) << $urandom_range(0, 30);
            end
            7: begin
                a = 31'($urandom_range(1, OPERAND_MAX));
                b = a;
            end
            8: begin
                a = 31'($urandom_range(1, OPERAND_MAX));
                b = 31'(a * $urandom_range(1, 15));
                if (b == 0)
                    b = 31'd1;
            end
            default: begin
                a = $urandom_range(0, 1) ? 31'(0) : 31'($urandom_range(0, OPERAND_MAX));
                b = (a != 0) ? 31'(0) : 31'($urandom_range(0, OPERAND_MAX));
            end
        endcase
        if ($urandom_range(0, 1)) begin
            factor = 32'(a);
            a = b;
            b = factor[30:0];
        end
    endtask

    // Stimulus and verdict.
    initial begin
        bit [30:0] a;
        bit [30:0] b;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        send_quiet = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pairs: zero operands, extremes, equal values, coprime and
        // power-of-two operands.
        send_pair(31'd0, 31'd0);
        send_pair(31'd0, 31'd12345);
        send_pair(31'd777, 31'd0);
        send_pair(31'd0, OPERAND_MAX);
        send_pair(OPERAND_MAX, 31'd0);
        send_pair(31'd1, 31'd1);
        send_pair(OPERAND_MAX, OPERAND_MAX);
        send_pair(OPERAND_MAX, 31'd1);
        send_pair(31'd1, OPERAND_MAX);
        send_pair(OPERAND_MAX, OPERAND_MAX - 31'd1);
        send_pair(OPERAND_MAX - 31'd1, OPERAND_MAX);
        send_pair(31'd12, 31'd18);
        send_pair(31'd18, 31'd12);
        send_pair(31'h4000_0000, 31'h2000_0000);
        send_pair(31'h4000_0000, 31'h4000_0000);
        send_pair(31'h4000_0000, OPERAND_MAX);
        send_pair(31'd2147483629, 31'd2147483587);
        send_pair(31'h5555_5555, 31'h2AAA_AAAA);
        send_pair(31'd42, 31'd42);
        send_pair(31'd1, 31'd2);
        send_pair(31'd65536, 31'd65535);
        send_pair(31'h7FFF_FFFE, 31'd2);

        // Random pairs, with bursts where the source never pauses.
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            if (i % 41 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            make_pair(a, b);
            send_pair(a, b);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Wait for every outstanding result, then watch for stray words.
        while (pending_count != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/gle_pkg.sv
design/gle_datapath.sv
design/gle_controller.sv
design/gcd_lcm_engine_core.sv
dv/gcd_lcm_checker.sv
dv/tb_gcd_lcm_engine_core.sv
